[src/bdq_pkg.sv]
// Package for the bounded deque: action and status codes, default sizes and the
// transaction structs of the request and response channels.
// No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam logic [2:0] ACT_NONE       = 3'd0;
   localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
   localparam logic [2:0] ACT_POP_BACK   = 3'd4;
   localparam logic [2:0] ACT_CLEAR      = 3'd5;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] front_word;
      logic [31:0] back_word;
      logic [4:0]  entry_count;
      logic        is_empty;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [4:0] entry_count;
      logic       is_empty;
      logic [1:0] status;
   } info_type;

endpackage

[src/bounded_deque_top.sv]
// Top level of the bounded deque: pointer control, slot memory and the response
// register, with assertions at the end.
// Depends on bdq_pkg, bdq_ctrl and bdq_slots.
//
// Usage: drive req_data with an action and a value and raise start; the
// transaction is accepted at the rising edge where start is high and busy is
// low. Busy stays low, so a new transaction may be issued on every cycle.
// Exactly one response follows each transaction, in the cycle after acceptance:
// rsp_strobe is high for that single cycle and rsp_data carries the front and
// back words, the entry count, the empty flag and the status. The receiver
// cannot stall; a response not taken in its cycle is gone.
// Throughput is one transaction per cycle. The slot write and both slot
// reads happen at the accepting edge, with the written word forwarded to the
// read ports, so the response words come from the registered read of the slot
// memory.
// Reset is synchronous and active high; it empties the deque and drops any
// pending response. Slot contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module bounded_deque_top
   import bdq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EXT_W = (WORD_BITS > 32) ? WORD_BITS : 32;

   logic                 accept;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr, front_addr, back_addr;
   logic [WORD_BITS-1:0] wr_data, front_data, back_data;
   logic [EXT_W-1:0]     value_ext, front_ext, back_ext;
   info_type             info, info_ff;
   logic                 strobe_ff;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign value_ext = EXT_W'(req_data.value);
   assign wr_data   = value_ext[WORD_BITS-1:0];

   bdq_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_data.action),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .front_addr (front_addr),
      .back_addr  (back_addr),
      .info       (info)
   );

   bdq_slots #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS),
      .IDX_W     (IDX_W)
   ) u_slots (
      .clock      (clock),
      .rd_en      (accept),
      .wr_en      (wr_en && accept),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .front_addr (front_addr),
      .back_addr  (back_addr),
      .front_data (front_data),
      .back_data  (back_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff <= info;
      end
   end

   assign front_ext = EXT_W'(front_data);
   assign back_ext  = EXT_W'(back_data);

   assign rsp_strobe           = strobe_ff;
   assign rsp_data.front_word  = info_ff.is_empty ? 32'd0 : front_ext[31:0];
   assign rsp_data.back_word   = info_ff.is_empty ? 32'd0 : back_ext[31:0];
   assign rsp_data.entry_count = info_ff.entry_count;
   assign rsp_data.is_empty    = info_ff.is_empty;
   assign rsp_data.status      = info_ff.status;

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted transaction produced no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response without an accepted transaction");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_FULL) |-> rsp_data.entry_count == 5'(DEPTH))
      else $error("push dropped while the deque was not full");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_EMPTY) |->
         (rsp_data.is_empty && rsp_data.front_word == 32'd0))
      else $error("pop ignored while the deque held entries");

endmodule

[src/bdq_ctrl.sv]
// Head pointer and entry count of the bounded deque, with the slot addresses
// that each transaction writes and reads.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_ctrl
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [2:0]       action,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr,
   output logic [IDX_W-1:0] front_addr,
   output logic [IDX_W-1:0] back_addr,
   output info_type         info
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in, count_m1;
   logic [IDX_W:0]   tail_sum, back_sum;
   logic [1:0]       status;

   always_comb begin
      tail_sum = {1'b0, head_ff} + (IDX_W + 1)'(count_ff);
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = (tail_sum >= DEPTH_X) ? IDX_W'(tail_sum - DEPTH_X) : IDX_W'(tail_sum);
      status   = ST_DONE;
      case (action)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (count_ff == FULL_CNT) begin
               status = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (action == ACT_PUSH_FRONT) begin
                  head_in = (head_ff == '0) ? LAST_IDX : head_ff - IDX_W'(1);
                  wr_addr = head_in;
               end
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (action == ACT_POP_FRONT) begin
                  head_in = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
               end
            end
         end
         ACT_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
      count_m1   = count_in - CNT_W'(1);
      back_sum   = {1'b0, head_in} + (IDX_W + 1)'(count_m1);
      front_addr = head_in;
      back_addr  = (back_sum >= DEPTH_X) ? IDX_W'(back_sum - DEPTH_X) : IDX_W'(back_sum);
      info.entry_count = 5'(count_in);
      info.is_empty    = (count_in == '0);
      info.status      = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

[src/bdq_slots.sv]
// Slot memory of the bounded deque: one write port and two registered read
// ports, with the word written in the same cycle forwarded to either read port.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_slots
   import bdq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT,
   parameter int IDX_W     = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [IDX_W-1:0]     front_addr,
   input  logic [IDX_W-1:0]     back_addr,
   output logic [WORD_BITS-1:0] front_data,
   output logic [WORD_BITS-1:0] back_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] front_ff, back_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         front_ff <= (wr_en && wr_addr == front_addr) ? wr_data : mem[front_addr];
         back_ff  <= (wr_en && wr_addr == back_addr) ? wr_data : mem[back_addr];
      end
   end

   assign front_data = front_ff;
   assign back_data  = back_ff;

endmodule

[tb/tb.sv]
// Self-checking testbench for bounded_deque_top: a directed opening table, then
// random action sequences, checked against table views or an in-bench ring model.
// Depends on bdq_pkg and bounded_deque_top.
`timescale 1ns / 1ps

module tb;
   import bdq_pkg::*;

   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;
   localparam int SLOT_COUNT = DEPTH_DEFAULT;
   localparam int OPENING_ROWS = 26;
   localparam int RANDOM_ITEMS = 1900;
   localparam int VIEW_SLOTS = 8;

   localparam rsp_type NO_VIEW = '0;
   localparam rsp_type BARE_VIEW = '{32'h0, 32'h0, 5'd0, 1'b1, ST_DONE};
   localparam rsp_type DRY_POP_VIEW = '{32'h0, 32'h0, 5'd0, 1'b1, ST_EMPTY};

   typedef struct packed {
      req_type cmd;
      logic    known;
      rsp_type view;
   } opening_row_type;

   opening_row_type opening_rows [OPENING_ROWS] = '{
      '{'{ACT_POP_FRONT, 32'h0000_0000}, 1'b1, DRY_POP_VIEW},
      '{'{ACT_POP_BACK, 32'hFFFF_FFFF}, 1'b1, DRY_POP_VIEW},
      '{'{ACT_NONE, 32'h0000_0000}, 1'b1, BARE_VIEW},
      '{'{ACT_CLEAR, 32'hA5A5_A5A5}, 1'b1, BARE_VIEW},
      '{'{ACT_PUSH_BACK, 32'hFFFF_FFFF}, 1'b1,
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0, ST_DONE}},
      '{'{ACT_PUSH_FRONT, 32'h0000_0000}, 1'b1,
        '{32'h0000_0000, 32'hFFFF_FFFF, 5'd2, 1'b0, ST_DONE}},
      '{'{ACT_SPARE_6, 32'h1234_5678}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_FRONT, 32'h8000_0000}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_BACK, 32'h0000_0001}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_FRONT, 32'h4000_0000}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_BACK, 32'h0000_0002}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_FRONT, 32'h2000_0000}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_BACK, 32'h0000_0004}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_FRONT, 32'h1000_0000}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_BACK, 32'h0000_0008}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_FRONT, 32'h0F0F_0F0F}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_BACK, 32'hF0F0_F0F0}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_FRONT, 32'h5555_5555}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_BACK, 32'hAAAA_AAAA}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_FRONT, 32'h7FFF_FFFF}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_BACK, 32'hFFFF_FFFE}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_FRONT, 32'h1111_1111}, 1'b0, NO_VIEW},
      '{'{ACT_PUSH_BACK, 32'h2222_2222}, 1'b0, NO_VIEW},
      '{'{ACT_POP_BACK, 32'h0000_0000}, 1'b0, NO_VIEW},
      '{'{ACT_POP_FRONT, 32'h0000_0000}, 1'b0, NO_VIEW},
      '{'{ACT_CLEAR, 32'h0000_0000}, 1'b1, BARE_VIEW}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   logic    given_known = 1'b0;
   rsp_type given_view = '0;

   logic [31:0] ring_words [SLOT_COUNT];
   logic [3:0]  ring_head;
   logic [4:0]  ring_fill;
   rsp_type     view_fifo [VIEW_SLOTS];
   logic [2:0]  view_rd_ptr = 3'd0;
   logic [2:0]  view_wr_ptr = 3'd0;
   int          view_fill = 0;
   int          fault_count = 0;

   bounded_deque_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #6 clock = ~clock;

   task automatic deque_apply(input req_type cmd, output rsp_type outcome);
      logic [1:0] code;
      logic [3:0] tail;
      code = ST_DONE;
      case (cmd.action)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (ring_fill == SLOT_COUNT) begin
               code = ST_FULL;
            end else if (cmd.action == ACT_PUSH_FRONT) begin
               ring_head = ring_head - 4'd1;
               ring_words[ring_head] = cmd.value;
               ring_fill = ring_fill + 5'd1;
            end else begin
               tail = ring_head + ring_fill[3:0];
               ring_words[tail] = cmd.value;
               ring_fill = ring_fill + 5'd1;
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (ring_fill == 5'd0) begin
               code = ST_EMPTY;
            end else begin
               if (cmd.action == ACT_POP_FRONT) ring_head = ring_head + 4'd1;
               ring_fill = ring_fill - 5'd1;
            end
         end
         ACT_CLEAR: begin
            ring_head = 4'd0;
            ring_fill = 5'd0;
         end
         default: ;
      endcase
      outcome = '0;
      if (ring_fill != 5'd0) begin
         tail = ring_head + ring_fill[3:0] - 4'd1;
         outcome.front_word = ring_words[ring_head];
         outcome.back_word = ring_words[tail];
      end
      outcome.entry_count = ring_fill;
      outcome.is_empty = (ring_fill == 5'd0);
      outcome.status = code;
   endtask

   function automatic void note_fault(string what, rsp_type want, rsp_type got);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t %s: expected front %h back %h count %0d empty %b status %0d",
                  $realtime, what, want.front_word, want.back_word, want.entry_count,
                  want.is_empty, want.status);
         $display("%0t %s: got front %h back %h count %0d empty %b status %0d",
                  $realtime, what, got.front_word, got.back_word,
                  got.entry_count, got.is_empty, got.status);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type want;
      if (reset) begin
         ring_head = 4'd0;
         ring_fill = 5'd0;
         view_rd_ptr = 3'd0;
         view_wr_ptr = 3'd0;
         view_fill = 0;
      end else begin
         if (rsp_strobe) begin
            if (view_fill == 0) begin
               note_fault("unexpected transaction", NO_VIEW, rsp_data);
            end else begin
               want = view_fifo[view_rd_ptr];
               view_rd_ptr = view_rd_ptr + 3'd1;
               view_fill--;
               if (rsp_data.front_word !== want.front_word
                   || rsp_data.back_word !== want.back_word
                   || rsp_data.entry_count !== want.entry_count
                   || rsp_data.is_empty !== want.is_empty
                   || rsp_data.status !== want.status)
                  note_fault("mismatch", want, rsp_data);
            end
         end
         if (start && !busy) begin
            deque_apply(req_data, predicted);
            view_fifo[view_wr_ptr] = given_known ? given_view : predicted;
            view_wr_ptr = view_wr_ptr + 3'd1;
            view_fill++;
         end
      end
   end

   task automatic issue(input req_type cmd, input logic known, input rsp_type view,
                        input bit quiet);
      while (!quiet && $urandom_range(99) < 34) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= cmd;
      given_known <= known;
      given_view <= view;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      req_type cmd;
      int meaningful;
      int mode_left;
      int push_weight;
      int roll;
      int spin;
      meaningful = 0;
      mode_left = 0;
      push_weight = 50;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_rows[i])
         issue(opening_rows[i].cmd, opening_rows[i].known, opening_rows[i].view, 1'b0);

      // Alternate filling, draining and balanced runs so that both the full and
      // the empty boundary are crossed many times.
      while (meaningful < RANDOM_ITEMS) begin
         if (mode_left == 0) begin
            mode_left = $urandom_range(60, 15);
            case ($urandom_range(2))
               0: push_weight = 80;
               1: push_weight = 20;
               default: push_weight = 50;
            endcase
         end
         mode_left--;
         roll = $urandom_range(99);
         if (roll < 3) begin
            case ($urandom_range(2))
               0: cmd.action = ACT_NONE;
               1: cmd.action = ACT_SPARE_6;
               default: cmd.action = ACT_SPARE_7;
            endcase
         end else if (roll < 5) begin
            cmd.action = ACT_CLEAR;
         end else if ($urandom_range(99) < push_weight) begin
            cmd.action = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
         end else begin
            cmd.action = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
         end
         case ($urandom_range(9))
            0: cmd.value = 32'h0000_0000;
            1: cmd.value = 32'hFFFF_FFFF;
            default: cmd.value = $urandom;
         endcase
         issue(cmd, 1'b0, NO_VIEW, meaningful >= 900 && meaningful < 1200);
         if (cmd.action >= ACT_PUSH_FRONT && cmd.action <= ACT_CLEAR) meaningful++;
      end
      start <= 1'b0;
      given_known <= 1'b0;

      for (spin = 0; spin < 200 && view_fill != 0; spin++)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (view_fill != 0) begin
         $display("%0t %0d expected transactions never arrived", $realtime,
                  view_fill);
         fault_count += view_fill;
      end
      if (fault_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
